/* rtl/tla_pkg.sv */
// Shared types and constants of the two-level temperature alarm.
`default_nettype none
package tla_pkg;

  localparam int TEMP_W  = 12;
  localparam int DELTA_W = 10;
  localparam int TIME_W  = 16;
  localparam int DWELL_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_DWELL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AL_DWELL  = 2'd3;

  // Reset values: 22.0 and 23.0 degrees in 1/16 units, 3000 ms dwell
  localparam logic signed [TEMP_W-1:0] LOW_THR_RST  = 12'sd352;
  localparam logic signed [TEMP_W-1:0] HIGH_THR_RST = 12'sd368;
  localparam logic [DWELL_W-1:0]       DWELL_RST    = 16'd3000;
  localparam logic [TIME_W-1:0]        TIME_MAX     = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_CHECK_PRE = 3'd1,
    MODE_PRE       = 3'd2,
    MODE_CHECK_AL  = 3'd3,
    MODE_ALARM     = 3'd4
  } mode_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] low_thr;
    logic signed [TEMP_W-1:0] high_thr;
    logic [DWELL_W-1:0]       pre_dwell;
    logic [DWELL_W-1:0]       al_dwell;
  } cfg_t;

  typedef struct packed {
    logic                     door_open;
    logic                     reset_pressed;
    logic [DELTA_W-1:0]       delta_ms;
    logic signed [TEMP_W-1:0] temperature;
  } tick_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] time_in_mode;
    logic              entry_pending;
    logic              pre_alarm_held;
    logic              alarm_held;
    logic              lamp_held;
  } alarm_state_t;

  typedef struct packed {
    logic  close_door;
    logic  clear_display;
    logic  show_alarm_text;
    logic  led_on;
    logic  alarm_flag;
    logic  pre_alarm_flag;
    mode_t mode;
  } result_t;

endpackage
`default_nettype wire

/* rtl/tla_step.sv */
// Combinational mode update for one tick request.
`default_nettype none
module tla_step
  import tla_pkg::*;
(
  input  var cfg_t         cfg,
  input  var alarm_state_t cur,
  input  var tick_t        tick,
  output alarm_state_t     nxt,
  output result_t          res
);

  logic                hi;
  logic                lo;
  logic [TIME_W:0]     time_sum;
  logic [TIME_W-1:0]   time_sat;
  logic                show;
  logic                clr;
  logic                close_cmd;

  assign hi = $signed(tick.temperature) >= $signed(cfg.high_thr);
  assign lo = $signed(tick.temperature) >= $signed(cfg.low_thr);
  assign time_sum = {1'b0, cur.time_in_mode} + {{(TIME_W + 1 - DELTA_W){1'b0}}, tick.delta_ms};
  assign time_sat = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];

  always_comb begin
    mode_t next_mode;
    logic  change;
    next_mode = cur.mode;
    change    = 1'b0;
    nxt       = cur;
    nxt.time_in_mode = time_sat;
    show      = 1'b0;
    clr       = 1'b0;
    close_cmd = 1'b0;
    case (cur.mode)
      MODE_CHECK_PRE: begin
        if (hi) begin
          next_mode = MODE_CHECK_AL; change = 1'b1;
        end else if (!lo) begin
          next_mode = MODE_NORMAL; change = 1'b1;
        end else if (time_sat >= cfg.pre_dwell) begin
          next_mode = MODE_PRE; change = 1'b1;
        end
      end
      MODE_PRE: begin
        if (cur.entry_pending) begin
          nxt.pre_alarm_held = 1'b1;
        end
        nxt.entry_pending = 1'b0;
        if (hi) begin
          next_mode = MODE_CHECK_AL; change = 1'b1;
        end else if (!lo) begin
          next_mode = MODE_NORMAL; change = 1'b1;
        end
      end
      MODE_CHECK_AL: begin
        if (!hi) begin
          next_mode = MODE_PRE; change = 1'b1;
        end else if (time_sat >= cfg.al_dwell) begin
          next_mode = MODE_ALARM; change = 1'b1;
        end
      end
      MODE_ALARM: begin
        if (cur.entry_pending) begin
          nxt.alarm_held = 1'b1;
          nxt.lamp_held  = 1'b1;
          show           = 1'b1;
          close_cmd      = tick.door_open;
        end
        nxt.entry_pending = 1'b0;
        if (tick.reset_pressed) begin
          clr = 1'b1;
          next_mode = MODE_NORMAL; change = 1'b1;
        end
      end
      default: begin
        // Normal, and any unused code, which falls back to normal
        next_mode = MODE_NORMAL;
        if (cur.entry_pending) begin
          nxt.pre_alarm_held = 1'b0;
          nxt.alarm_held     = 1'b0;
          nxt.lamp_held      = 1'b0;
        end
        nxt.entry_pending = 1'b0;
        if (hi) begin
          next_mode = MODE_CHECK_AL; change = 1'b1;
        end else if (lo) begin
          next_mode = MODE_CHECK_PRE; change = 1'b1;
        end
      end
    endcase
    nxt.mode = next_mode;
    if (change) begin
      nxt.time_in_mode  = '0;
      nxt.entry_pending = 1'b1;
    end
  end

  always_comb begin
    res.mode            = nxt.mode;
    res.pre_alarm_flag  = nxt.pre_alarm_held;
    res.alarm_flag      = nxt.alarm_held;
    res.led_on          = nxt.lamp_held;
    res.show_alarm_text = show;
    res.clear_display   = clr;
    res.close_door      = close_cmd;
  end

endmodule
`default_nettype wire

/* rtl/two_level_temperature_alarm.sv */
// Top level of the two-level temperature alarm: registers, handshake and configuration.
//
// Usage:
//   One request on the in_ stream per task tick: temperature, delta_ms, button and
//   door levels packed in in_tdata. Each request gives exactly one result request on
//   the out_ stream: the mode after the tick, the held pre-alarm / alarm / lamp levels
//   and the one-tick pulses for alarm text, display clear and door close.
//   Thresholds and dwell times sit on the cfg_ write port, written while idle.
// Pipeline and throughput:
//   A request is captured in an input register, evaluated by the single-pass mode
//   update and lands in the result register, which raises out_tvalid.
//   One request per cycle is sustained while out_tready stays high; the mode state
//   feeds back from the combinational update into the state register.
// Reset:
//   rst_n low returns the block to normal mode with entry pending, time in mode zero,
//   all flags and the lamp clear, and the configuration at 22.0 / 23.0 degrees and
//   3000 ms dwells. Both pipeline registers come up empty.
// Stall:
//   With out_tready low the result holds; the input register still takes one more
//   request, after which in_tready drops until the result is taken.
`default_nettype none
module two_level_temperature_alarm
  import tla_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  // Input stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // in_tdata: temperature[11:0], delta_ms[21:12], reset_pressed[22], door_open[23]
  input  wire  [IN_DATA_W-1:0]   in_tdata,
  // Result stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // out_tdata: mode[2:0], pre_alarm_flag[3], alarm_flag[4], led_on[5],
  //            show_alarm_text[6], clear_display[7], close_door[8], zeros above
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // Configuration write port
  input  wire                    cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_W-1:0]       cfg_wdata
);

  cfg_t         cfg_r;
  alarm_state_t state_r;
  alarm_state_t state_nxt;
  tick_t        tick_r;
  logic         in_valid_r;
  result_t      res_r;
  result_t      res_nxt;
  logic         out_valid_r;
  logic         advance;

  // Input register moves into the result register when the latter is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr   <= LOW_THR_RST;
      cfg_r.high_thr  <= HIGH_THR_RST;
      cfg_r.pre_dwell <= DWELL_RST;
      cfg_r.al_dwell  <= DWELL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOW_THR:   cfg_r.low_thr   <= $signed(cfg_wdata[TEMP_W-1:0]);
        REG_HIGH_THR:  cfg_r.high_thr  <= $signed(cfg_wdata[TEMP_W-1:0]);
        REG_PRE_DWELL: cfg_r.pre_dwell <= cfg_wdata[DWELL_W-1:0];
        REG_AL_DWELL:  cfg_r.al_dwell  <= cfg_wdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tick_r <= tick_t'(in_tdata);
    end
  end

  tla_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .tick (tick_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Mode state advances once per evaluated tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode           <= MODE_NORMAL;
      state_r.time_in_mode   <= '0;
      state_r.entry_pending  <= 1'b1;
      state_r.pre_alarm_held <= 1'b0;
      state_r.alarm_held     <= 1'b0;
      state_r.lamp_held      <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_r};

  // Alarm text only on an alarm entry tick, with flag and lamp already set
  // (the button may send the mode straight back to normal on that tick)
  a_show_in_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.show_alarm_text) |->
      (res_r.alarm_flag && res_r.led_on))
    else $error("alarm text outside alarm entry");

  // Door close is a subset of the alarm entry pulse
  a_close_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.close_door) |-> res_r.show_alarm_text)
    else $error("door close without alarm entry");

  // Display clear only when leaving alarm for normal
  a_clear_to_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.clear_display) |-> (res_r.mode == MODE_NORMAL))
    else $error("display clear not on return to normal");

  // An evaluated tick always shows up in the result register next cycle
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated tick lost");

  // A mode change out of any mode other than normal restarts the time in mode
  a_time_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_nxt.mode != state_r.mode && state_r.mode != MODE_NORMAL)
      |=> (state_r.time_in_mode == '0 && state_r.entry_pending))
    else $error("mode change without time restart");

endmodule
`default_nettype wire
